// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; reset is synchronous, active low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/ubs_pkg.sv
// ----------------------------------------------------------------------------
// ubs_pkg
// Types and constants for the UART bit sequencer.
// ----------------------------------------------------------------------------
package ubs_pkg;

  // Data phase ends once the counter reaches this value.
  localparam logic [3:0] LAST_DATA_COUNT = 4'd7;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_LOAD     = 11'b000_0000_0010,
    PH_TX_START = 11'b000_0000_0100,
    PH_TX_DATA  = 11'b000_0000_1000,
    PH_TX_PAR   = 11'b000_0001_0000,
    PH_TX_STOP  = 11'b000_0010_0000,
    PH_RX_START = 11'b000_0100_0000,
    PH_RX_DATA  = 11'b000_1000_0000,
    PH_RX_PAR   = 11'b001_0000_0000,
    PH_RX_STOP  = 11'b010_0000_0000,
    PH_ERROR    = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic soft_reset;
    logic tx_full;
    logic line_in;
    logic parity_bad;
  } in_item_t;

  typedef struct packed {
    logic load_strobe;
    logic tx_start_strobe;
    logic tx_data_strobe;
    logic tx_parity_strobe;
    logic tx_stop_strobe;
    logic rx_start_strobe;
    logic rx_data_strobe;
    logic rx_parity_strobe;
    logic rx_stop_strobe;
    logic error_strobe;
    logic sent_flag;
    logic received_flag;
  } out_item_t;

  // Input register contents handed to the sequencer.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_beat_t;

endpackage

// File: rtl/ubs_in_reg.sv
// ----------------------------------------------------------------------------
// ubs_in_reg
// Input register stage; holds one beat until the sequencer takes it.
// ----------------------------------------------------------------------------
module ubs_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ubs_pkg::in_item_t in_data,
  input  logic              take,
  output ubs_pkg::in_beat_t beat
);

  logic              valid_r;
  logic              valid_nxt;
  ubs_pkg::in_item_t item_r;

  // Stage frees up when empty or when its beat moves on this cycle.
  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  assign beat.valid = valid_r;
  assign beat.item  = item_r;

endmodule

// File: rtl/ubs_fsm.sv
// ----------------------------------------------------------------------------
// ubs_fsm
// Frame phase machine, bit counter, sticky flags and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubs_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  ubs_pkg::in_beat_t  beat,
  output logic               take,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ubs_pkg::out_item_t out_data
);

  ubs_pkg::phase_t    phase_r, phase_nxt, phase_mv;
  logic [3:0]         bit_count_r, bit_count_nxt;
  logic               sent_r, sent_nxt;
  logic               rcvd_r, rcvd_nxt;
  logic               parity_on_r, parity_on_nxt;
  logic               out_valid_r, out_valid_nxt;
  ubs_pkg::out_item_t out_data_r, out_data_nxt;
  logic [9:0]         strb;
  logic               step;
  logic               last_bit;
  ubs_pkg::in_item_t  it;

  assign it       = beat.item;
  assign take     = !out_valid_r || !out_stall;
  assign step     = beat.valid && take;
  assign last_bit = bit_count_r >= ubs_pkg::LAST_DATA_COUNT;

  // Next phase and strobe set; strb bit 9 is load, bit 0 is error.
  always_comb begin
    phase_mv = ubs_pkg::PH_IDLE;
    strb     = 10'b0;
    unique case (phase_r)
      ubs_pkg::PH_IDLE: begin
        if (!it.tx_full) begin
          phase_mv = ubs_pkg::PH_LOAD;
          strb[9]  = 1'b1;
        end else if (!it.line_in) begin
          phase_mv = ubs_pkg::PH_RX_START;
          strb[4]  = 1'b1;
        end
      end
      ubs_pkg::PH_LOAD: begin
        phase_mv = ubs_pkg::PH_TX_START;
        strb[8]  = 1'b1;
      end
      ubs_pkg::PH_TX_START: begin
        phase_mv = ubs_pkg::PH_TX_DATA;
        strb[7]  = 1'b1;
      end
      ubs_pkg::PH_TX_DATA: begin
        strb[7] = 1'b1;
        if (last_bit) begin
          phase_mv = parity_on_r ? ubs_pkg::PH_TX_PAR : ubs_pkg::PH_TX_STOP;
        end else begin
          phase_mv = ubs_pkg::PH_TX_DATA;
        end
      end
      ubs_pkg::PH_TX_PAR: begin
        strb[6]  = 1'b1;
        phase_mv = ubs_pkg::PH_TX_STOP;
      end
      ubs_pkg::PH_TX_STOP: begin
        strb[5]  = 1'b1;
        phase_mv = it.tx_full ? ubs_pkg::PH_IDLE : ubs_pkg::PH_LOAD;
      end
      ubs_pkg::PH_RX_START: begin
        strb[4]  = 1'b1;
        phase_mv = ubs_pkg::PH_RX_DATA;
      end
      ubs_pkg::PH_RX_DATA: begin
        strb[3] = 1'b1;
        if (last_bit) begin
          phase_mv = parity_on_r ? ubs_pkg::PH_RX_PAR : ubs_pkg::PH_RX_STOP;
        end else begin
          phase_mv = ubs_pkg::PH_RX_DATA;
        end
      end
      ubs_pkg::PH_RX_PAR: begin
        strb[2]  = 1'b1;
        phase_mv = it.parity_bad ? ubs_pkg::PH_ERROR : ubs_pkg::PH_RX_STOP;
      end
      ubs_pkg::PH_RX_STOP: begin
        strb[1]  = 1'b1;
        phase_mv = it.line_in ? ubs_pkg::PH_IDLE : ubs_pkg::PH_ERROR;
      end
      ubs_pkg::PH_ERROR: begin
        strb[0]  = 1'b1;
        phase_mv = ubs_pkg::PH_IDLE;
      end
      default: begin
        phase_mv = ubs_pkg::PH_IDLE;
      end
    endcase
  end

  // State update for one beat.
  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    sent_nxt      = sent_r;
    rcvd_nxt      = rcvd_r;
    parity_on_nxt = cfg_valid ? cfg_data : parity_on_r;
    if (step) begin
      if (it.soft_reset) begin
        phase_nxt     = ubs_pkg::PH_IDLE;
        bit_count_nxt = 4'd0;
        sent_nxt      = 1'b0;
        rcvd_nxt      = 1'b0;
        parity_on_nxt = 1'b0;
      end else begin
        phase_nxt = phase_mv;
        if (phase_mv == ubs_pkg::PH_TX_DATA || phase_mv == ubs_pkg::PH_RX_DATA) begin
          bit_count_nxt = bit_count_r + 4'd1;
        end
        if (phase_mv == ubs_pkg::PH_LOAD || phase_mv == ubs_pkg::PH_RX_START) begin
          bit_count_nxt = 4'd0;
        end
        if (phase_mv == ubs_pkg::PH_TX_STOP) begin
          sent_nxt = 1'b1;
        end
        if (phase_mv == ubs_pkg::PH_RX_STOP && it.line_in) begin
          rcvd_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (it.soft_reset) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt.load_strobe      = strb[9];
      out_data_nxt.tx_start_strobe  = strb[8];
      out_data_nxt.tx_data_strobe   = strb[7];
      out_data_nxt.tx_parity_strobe = strb[6];
      out_data_nxt.tx_stop_strobe   = strb[5];
      out_data_nxt.rx_start_strobe  = strb[4];
      out_data_nxt.rx_data_strobe   = strb[3];
      out_data_nxt.rx_parity_strobe = strb[2];
      out_data_nxt.rx_stop_strobe   = strb[1];
      out_data_nxt.error_strobe     = strb[0];
      out_data_nxt.sent_flag        = sent_nxt;
      out_data_nxt.received_flag    = rcvd_nxt;
    end
  end

  assign out_valid_nxt = take ? beat.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ubs_pkg::PH_IDLE;
      bit_count_r <= 4'd0;
      sent_r      <= 1'b0;
      rcvd_r      <= 1'b0;
      parity_on_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      sent_r      <= sent_nxt;
      rcvd_r      <= rcvd_nxt;
      parity_on_r <= parity_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Bits 11..2 of the result are the ten phase strobes.
  `ASSERT_IMPLY(a_strb_onehot0, clk, rst_n, out_valid_r, $onehot0(out_data_r[11:2]))
  `ASSERT_NEXT(a_sent_sticky, clk, rst_n, sent_r && !(step && it.soft_reset), sent_r)
  `ASSERT_IMPLY(a_data_count, clk, rst_n, phase_r == ubs_pkg::PH_TX_DATA || phase_r == ubs_pkg::PH_RX_DATA, bit_count_r != 4'd0)
  `ASSERT_NEXT(a_err_to_idle, clk, rst_n, step && phase_r == ubs_pkg::PH_ERROR, phase_r == ubs_pkg::PH_IDLE)

endmodule

// File: rtl/uart_bit_sequencer_fsm.sv
// ----------------------------------------------------------------------------
// uart_bit_sequencer_fsm
// UART transceiver control sequencer, one input beat per bit-period tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per bit period (soft_reset, tx_full, line_in, parity_bad),
//           valid/stall handshake; accepted when in_valid && !in_stall.
//   out_* : exactly one result beat per input beat: the phase strobes (at most
//           one set) chosen this tick plus sticky sent/received flags.
//   cfg_* : single register parity_on, written when cfg_valid && cfg_ready.
//           cfg_ready is always high; write only while the block is idle.
// Path: a beat accepted into the input register is then taken by the phase
//   logic, which feeds the result register that drives out_*.
// Throughput: one beat per clock while out_stall is low.
// Stall: out_stall holds the result register; the input register fills and
//   in_stall then follows out_stall combinationally. Nothing is dropped.
// Reset: rst_n (sync, active low) empties both stages, returns to idle and
//   clears counter, flags and parity_on. A soft_reset beat returns to idle and
//   clears the same state in band, and yields an all-zero result.
// ----------------------------------------------------------------------------
module uart_bit_sequencer_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ubs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ubs_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  ubs_pkg::in_beat_t beat;
  logic              take;

  // Config is accepted any cycle; the user must keep writes away from live beats, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // Input register: parts the upstream handshake from the phase logic.
  ubs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .beat     (beat)
  );

  // Phase machine and result register.
  ubs_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .take      (take),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
